### src/som_pkg.sv
// Shared types and constants for the self-organizing map block.
// No dependencies; imported by every module under src.
package som_pkg;

    localparam int DataBits = 16;
    localparam int MaxDim   = 16;
    localparam int MaxNodes = 256;
    localparam int DistBits = 37;
    localparam int NodeBits = 8;
    localparam int CompBits = 4;
    localparam int AddrBits = NodeBits + CompBits;

    localparam logic [1:0] OpWrite    = 2'd0;
    localparam logic [1:0] OpRead     = 2'd1;
    localparam logic [1:0] OpTrain    = 2'd2;
    localparam logic [1:0] OpClassify = 2'd3;

    localparam logic [2:0] RegWidth  = 3'd0;
    localparam logic [2:0] RegHeight = 3'd1;
    localparam logic [2:0] RegLength = 3'd2;
    localparam logic [2:0] RegRadius = 3'd3;
    localparam logic [2:0] RegRate   = 3'd4;
    localparam logic [2:0] RegMetric = 3'd5;

    localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic mem_write_direct;   // host weight write
        logic mem_read_direct;    // host weight read
        logic sample_write;       // buffer the incoming sample element
        logic search_start;       // clear search state
        logic search_step;        // one element of the distance walk
        logic update_step;        // one element of the update walk
        logic update_writeback;   // write the updated element
    } som_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;          // last element of last node issued
        logic in_window;          // current node lies inside the update window
    } som_stat_t;

    function automatic logic [4:0] clamp_dim(input logic [4:0] v);
        logic [4:0] r;
        r = v;
        if (v == 5'd0) r = 5'd1;
        else if (v > 5'd16) r = 5'd16;
        return r;
    endfunction

endpackage

### src/som_ctrl.sv
// Controller state machine for the self-organizing map block.
// Depends on som_pkg; drives the datapath through som_cmd_t.
module som_ctrl
    import som_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic [1:0]  op,
    input  logic        last,
    input  som_stat_t   stat,
    input  logic        out_free,
    output logic        in_ready,
    output logic        load_read,
    output logic        load_win,
    output som_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_READ   = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_DRAIN  = 7'b0001000,
        ST_UPD    = 7'b0010000,
        ST_UWB    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   train_reg, train_next;
    logic [1:0] drain_reg, drain_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        train_next = train_reg;
        drain_next = drain_reg;
        cmd        = '0;
        load_read  = 1'b0;
        load_win   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op)
                        OpWrite: cmd.mem_write_direct = 1'b1;
                        OpRead:
                        begin
                            cmd.mem_read_direct = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            cmd.sample_write = 1'b1;
                            if (last)
                            begin
                                cmd.search_start = 1'b1;
                                train_next = (op == OpTrain);
                                state_next = ST_SEARCH;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load_read  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (stat.walk_done)
                begin
                    drain_next = 2'd0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // Pipeline of read, difference and square or absolute term must empty.
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd3)
                begin
                    cmd.search_start = train_reg;
                    state_next = train_reg ? ST_UPD : ST_OUT;
                end
            end
            ST_UPD:
            begin
                cmd.update_step = 1'b1;
                state_next = ST_UWB;
            end
            ST_UWB:
            begin
                cmd.update_writeback = 1'b1;
                state_next = stat.walk_done ? ST_OUT : ST_UPD;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    load_win   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            train_reg <= 1'b0;
            drain_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            train_reg <= train_next;
            drain_reg <= drain_next;
        end
    end

endmodule

### src/som_datapath.sv
// Datapath of the self-organizing map block: weight memory, sample buffer,
// distance accumulator, winner compare and update arithmetic. Uses som_pkg.
module som_datapath
    import som_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  som_cmd_t             cmd,
    input  logic [NodeBits-1:0]  node,
    input  logic [CompBits-1:0]  component,
    input  logic [DataBits-1:0]  value,
    input  logic [4:0]           grid_width,
    input  logic [4:0]           grid_height,
    input  logic [4:0]           vector_length,
    input  logic [3:0]           radius,
    input  logic [15:0]          learning_rate,
    input  logic                 metric,
    output som_stat_t            stat,
    output logic [DataBits-1:0]  rd_value,
    output logic [NodeBits-1:0]  best_node,
    output logic [DistBits-1:0]  best_dist
);

    logic [DataBits-1:0] mem [0:MaxNodes*MaxDim-1];
    logic [DataBits-1:0] sample_reg [0:MaxDim-1];
    logic [DataBits-1:0] mem_q;

    logic [4:0] w_c, h_c, len_c;
    assign w_c   = clamp_dim(grid_width);
    assign h_c   = clamp_dim(grid_height);
    assign len_c = clamp_dim(vector_length);

    // Walk counters: row, column and element.
    logic [3:0] row_reg, col_reg, k_reg;
    logic       walk_reg;
    logic       last_k, last_node;
    assign last_k    = ({1'b0, k_reg} == len_c - 5'd1);
    assign last_node = ({1'b0, row_reg} == h_c - 5'd1) && ({1'b0, col_reg} == w_c - 5'd1);

    logic [NodeBits-1:0] nidx;
    always_comb
    begin
        nidx = NodeBits'({4'd0, row_reg} * {3'd0, w_c}) + NodeBits'(col_reg);
    end

    logic step;
    assign step = cmd.search_step || cmd.update_writeback;
    assign stat.walk_done = walk_reg && last_k && last_node;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            k_reg    <= '0;
            walk_reg <= 1'b0;
        end
        else if (cmd.search_start)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            k_reg    <= '0;
            walk_reg <= 1'b1;
        end
        else if (step && walk_reg)
        begin
            if (last_k)
            begin
                k_reg <= '0;
                if (last_node)
                    walk_reg <= 1'b0;
                else if ({1'b0, col_reg} == w_c - 5'd1)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 4'd1;
                end
                else
                    col_reg <= col_reg + 4'd1;
            end
            else
                k_reg <= k_reg + 4'd1;
        end
    end

    // Window test against the registered winner.
    logic [3:0] wrow_reg, wcol_reg;
    logic [3:0] dr, dc;
    assign dr = (row_reg > wrow_reg) ? row_reg - wrow_reg : wrow_reg - row_reg;
    assign dc = (col_reg > wcol_reg) ? col_reg - wcol_reg : wcol_reg - col_reg;
    assign stat.in_window = (dr <= radius) && (dc <= radius);

    // Memory port: one address per cycle, registered read data.
    logic [AddrBits-1:0] addr;
    always_comb
    begin
        if (cmd.mem_write_direct || cmd.mem_read_direct)
            addr = {node, component};
        else
            addr = {nidx, k_reg};
    end

    // Update arithmetic on the element read in the previous cycle.
    logic [DataBits-1:0] upd_s;
    logic signed [DataBits:0]    diff;
    logic signed [DataBits+17:0] prod;
    logic signed [DataBits+17:0] rnd;
    logic [AddrBits-1:0] upd_addr_reg;
    logic                upd_en_reg;
    assign upd_s = sample_reg[upd_addr_reg[CompBits-1:0]];
    assign diff  = $signed({upd_s[DataBits-1], upd_s}) - $signed({mem_q[DataBits-1], mem_q});
    assign prod  = diff * $signed({2'b00, learning_rate});
    assign rnd   = (prod + 34'sd32768) >>> 16;

    logic [DataBits-1:0] new_w;
    assign new_w = mem_q + rnd[DataBits-1:0];

    // Read data is held between reads so a waiting weight read keeps its beat.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write_direct)
            mem[addr] <= value;
        else if (cmd.update_writeback && upd_en_reg)
            mem[upd_addr_reg] <= new_w;
        if (cmd.mem_read_direct || cmd.search_step || cmd.update_step)
            mem_q <= mem[addr];
        if (cmd.sample_write)
            sample_reg[component] <= value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_addr_reg <= '0;
            upd_en_reg   <= 1'b0;
        end
        else if (cmd.update_step)
        begin
            upd_addr_reg <= addr;
            upd_en_reg   <= stat.in_window;
        end
    end

    assign rd_value = mem_q;

    // Distance pipeline: read, then absolute difference, then term, then sum.
    logic                v1_reg, v2_reg;
    logic                e1_reg, e2_reg;
    logic [NodeBits-1:0] n1_reg, n2_reg;
    logic [3:0]          r1_reg, r2_reg, c1_reg, c2_reg;
    logic [3:0]          brow_reg, bcol_reg;
    logic [CompBits-1:0] k1_reg;
    logic [DataBits-1:0] a_reg;
    logic signed [DataBits:0] sd;
    logic [DataBits:0]   ad;
    logic [DataBits:0]   abs_reg;
    logic [2*DataBits+1:0] term;
    logic [DistBits:0]   sum_next;
    logic [DistBits-1:0] acc_reg;
    logic [DistBits-1:0] dist_sat;

    assign a_reg = sample_reg[k1_reg];
    assign sd = $signed({a_reg[DataBits-1], a_reg}) - $signed({mem_q[DataBits-1], mem_q});
    assign ad = sd[DataBits] ? DataBits'(0) - sd : sd;
    assign term = metric ? {{(DataBits+1){1'b0}}, abs_reg} : abs_reg * abs_reg;
    assign sum_next = {1'b0, acc_reg} + (DistBits+1)'(term);
    assign dist_sat = sum_next[DistBits] ? DistMax : sum_next[DistBits-1:0];

    logic first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            e1_reg    <= 1'b0;
            e2_reg    <= 1'b0;
            n1_reg    <= '0;
            n2_reg    <= '0;
            r1_reg    <= '0;
            r2_reg    <= '0;
            c1_reg    <= '0;
            c2_reg    <= '0;
            brow_reg  <= '0;
            bcol_reg  <= '0;
            k1_reg    <= '0;
            abs_reg   <= '0;
            acc_reg   <= '0;
            best_node <= '0;
            best_dist <= '0;
            first_reg <= 1'b0;
            wrow_reg  <= '0;
            wcol_reg  <= '0;
        end
        else
        begin
            v1_reg  <= cmd.search_step && walk_reg;
            e1_reg  <= last_k;
            n1_reg  <= nidx;
            r1_reg  <= row_reg;
            c1_reg  <= col_reg;
            k1_reg  <= k_reg;
            v2_reg  <= v1_reg;
            e2_reg  <= e1_reg;
            n2_reg  <= n1_reg;
            r2_reg  <= r1_reg;
            c2_reg  <= c1_reg;
            abs_reg <= ad;
            if (cmd.search_start && !walk_reg)
                first_reg <= 1'b1;
            if (v2_reg)
            begin
                if (e2_reg)
                begin
                    acc_reg <= '0;
                    if (first_reg || dist_sat < best_dist)
                    begin
                        best_dist <= dist_sat;
                        best_node <= n2_reg;
                        brow_reg  <= r2_reg;
                        bcol_reg  <= c2_reg;
                    end
                    first_reg <= 1'b0;
                end
                else
                    acc_reg <= dist_sat;
            end
            // Winner row and column for the update window.
            if (cmd.update_step == 1'b0 && cmd.search_start)
            begin
                wrow_reg <= brow_reg;
                wcol_reg <= bcol_reg;
            end
        end
    end

endmodule

### src/som_winner_search_and_update.sv
// Top level of the self-organizing map block: configuration registers,
// output register, controller and datapath. Uses som_pkg.
//
// Usage: an input beat carries op, node, component, value and last.
// Write weight: stored, no result. Read weight: one result beat from the
// registered memory read through the output register. Train or classify
// elements are each buffered in the sample register; the element with
// last set starts a walk over all nodes of the configured grid, one
// element per cycle, then a pipeline drain; for training, a second walk
// reads each element and writes it back updated inside the update
// window. The result is loaded last.
// One item at a time: in_stall is high while a read or walk runs and until its result is loaded.
// Results sit in an output register until taken; while out_stall holds
// the register full, the block waits before the next result.
// Configuration writes are accepted in any cycle (cfg_ready high).
// Reset clears configuration to defaults and all control state; weights
// and sample elements hold no value until written.
module som_winner_search_and_update
    import som_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [NodeBits-1:0]  node,
    input  logic [CompBits-1:0]  component,
    input  logic [DataBits-1:0]  value,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DataBits-1:0]  read_value,
    output logic [NodeBits-1:0]  winner,
    output logic [DistBits-1:0]  winner_distance,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [4:0]  width_reg, height_reg, length_reg;
    logic [3:0]  radius_reg;
    logic [15:0] rate_reg;
    logic        metric_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 5'd16;
            height_reg <= 5'd16;
            length_reg <= 5'd16;
            radius_reg <= 4'd9;
            rate_reg   <= 16'd58982;
            metric_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                RegWidth:  width_reg  <= cfg_data[4:0];
                RegHeight: height_reg <= cfg_data[4:0];
                RegLength: length_reg <= cfg_data[4:0];
                RegRadius: radius_reg <= cfg_data[3:0];
                RegRate:   rate_reg   <= cfg_data;
                RegMetric: metric_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    som_cmd_t  cmd;
    som_stat_t stat;
    logic in_ready, in_fire, load_read, load_win, out_free;
    logic [DataBits-1:0] rd_value;
    logic [NodeBits-1:0] best_node;
    logic [DistBits-1:0] best_dist;

    assign in_stall = !in_ready;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid || !out_stall;

    som_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .op        (op),
        .last      (last),
        .stat      (stat),
        .out_free  (out_free),
        .in_ready  (in_ready),
        .load_read (load_read),
        .load_win  (load_win),
        .cmd       (cmd)
    );

    som_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .node          (node),
        .component     (component),
        .value         (value),
        .grid_width    (width_reg),
        .grid_height   (height_reg),
        .vector_length (length_reg),
        .radius        (radius_reg),
        .learning_rate (rate_reg),
        .metric        (metric_reg),
        .stat          (stat),
        .rd_value      (rd_value),
        .best_node     (best_node),
        .best_dist     (best_dist)
    );

    logic out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_read || load_win)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_read)
        begin
            read_value      <= rd_value;
            winner          <= '0;
            winner_distance <= '0;
        end
        else if (load_win)
        begin
            read_value      <= '0;
            winner          <= best_node;
            winner_distance <= best_dist;
        end
    end

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (load_read || load_win) |-> !in_ready)
        else $error("result loaded while accepting input");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !(load_read || load_win))
        else $error("held result overwritten");
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_read && load_win))
        else $error("two results at once");

endmodule

### sim/tb.sv
// Self-checking testbench for som_winner_search_and_update: weight access,
// winner search, neighborhood training and backpressure on both channels.
// Depends on som_pkg and the block's top level; reads and writes no files.
module tb;
    import som_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CycleLimit = 3000000;

    typedef struct {
        logic [DataBits-1:0] rd;
        logic [NodeBits-1:0] win;
        logic [DistBits-1:0] wdist;
    } som_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          op = OpWrite;
    logic [NodeBits-1:0] node = '0;
    logic [CompBits-1:0] component = '0;
    logic [DataBits-1:0] value = '0;
    logic                last = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DataBits-1:0] read_value;
    logic [NodeBits-1:0] winner;
    logic [DistBits-1:0] winner_distance;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = RegWidth;
    logic [15:0]         cfg_data = '0;

    som_winner_search_and_update uut (.*);

    always #4 clk = ~clk;

    // Predictor state: weights, sample buffer and active configuration.
    logic signed [DataBits-1:0] weights [0:MaxNodes-1][0:MaxDim-1];
    bit                         wt_known [0:MaxNodes-1][0:MaxDim-1];
    logic signed [DataBits-1:0] sample [0:MaxDim-1];
    bit                         smp_known [0:MaxDim-1];
    int                         cols = 16, rows = 16, vlen = 16;
    int                         rad = 9;
    longint                     rate = 58982;
    bit                         city_block = 1'b0;

    som_result_t pending_results [$];
    int          errors = 0;
    int          n_items = 0;
    int          n_trained = 0, n_classified = 0, n_reads = 0, n_results = 0;
    longint      cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stall: random bursts, or one long hold-off on request.
    int hold_left = 0, burst_left = 0;
    bit burst_stall = 1'b0;
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 14);
                burst_stall = ($urandom_range(0, 2) == 0);
            end
            burst_left--;
            out_stall <= burst_stall;
        end
    end

    // Result beats are taken at the next rising edge; inputs are stable here.
    always @(negedge clk)
    begin
        som_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: read %h winner %0d distance %0d",
                         $time, read_value, winner, winner_distance);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (read_value !== exp_r.rd)
                begin
                    errors++;
                    $display("%0t read_value expected %h actual %h",
                             $time, exp_r.rd, read_value);
                end
                if (winner !== exp_r.win)
                begin
                    errors++;
                    $display("%0t winner expected %0d actual %0d",
                             $time, exp_r.win, winner);
                end
                if (winner_distance !== exp_r.wdist)
                begin
                    errors++;
                    $display("%0t winner_distance expected %0d actual %0d",
                             $time, exp_r.wdist, winner_distance);
                end
            end
        end
    end

    function automatic longint node_dist(int n);
        longint sum, d;
        sum = 0;
        for (int k = 0; k < vlen; k++)
        begin
            d = longint'(sample[k]) - longint'(weights[n][k]);
            if (d < 0) d = -d;
            sum += city_block ? d : d * d;
            if (sum > longint'(DistMax)) sum = longint'(DistMax);
        end
        return sum;
    endfunction

    // Winner search over the active grid, then the window update for training.
    task automatic search_and_update(input logic [1:0] kind);
        int          best, wr, wc, r, c;
        longint      best_d, d, diff, p;
        som_result_t res;
        best = 0;
        best_d = node_dist(0);
        for (int n = 1; n < cols * rows; n++)
        begin
            d = node_dist(n);
            if (d < best_d)
            begin
                best_d = d;
                best = n;
            end
        end
        if (kind == OpTrain)
        begin
            wr = best / cols;
            wc = best % cols;
            for (int n = 0; n < cols * rows; n++)
            begin
                r = n / cols;
                c = n % cols;
                if ((r > wr ? r - wr : wr - r) <= rad && (c > wc ? c - wc : wc - c) <= rad)
                    for (int k = 0; k < vlen; k++)
                    begin
                        diff = longint'(sample[k]) - longint'(weights[n][k]);
                        p = diff * rate + 32768;
                        weights[n][k] = DataBits'(longint'(weights[n][k]) + (p >>> 16));
                    end
            end
            n_trained++;
        end
        else
            n_classified++;
        res.rd = '0;
        res.win = NodeBits'(best);
        res.wdist = DistBits'(best_d);
        pending_results.push_back(res);
    endtask

    task automatic predict(input logic [1:0] o, input int n, input int k,
                           input logic [15:0] v, input bit lst);
        som_result_t res;
        case (o)
            OpWrite:
            begin
                weights[n][k] = v;
                wt_known[n][k] = 1'b1;
            end
            OpRead:
            begin
                res.rd = weights[n][k];
                res.win = '0;
                res.wdist = '0;
                pending_results.push_back(res);
                n_reads++;
            end
            default:
            begin
                sample[k] = v;
                smp_known[k] = 1'b1;
                if (lst) search_and_update(o);
            end
        endcase
    endtask

    task automatic send_item(input logic [1:0] o, input int n, input int k,
                             input logic [15:0] v, input bit lst);
        bit st;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        node <= n;
        component <= k;
        value <= v;
        last <= lst;
        forever
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
            if (!st) break;
        end
        predict(o, n, k, v, lst);
        n_items++;
    endtask

    // Waits for every expected result, then for the longest training walk.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (3 * cols * rows * vlen + 40) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        bit rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
            if (rdy) break;
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            RegWidth:  cols = (data[4:0] == 0) ? 1 : (data[4:0] > 16 ? 16 : data[4:0]);
            RegHeight: rows = (data[4:0] == 0) ? 1 : (data[4:0] > 16 ? 16 : data[4:0]);
            RegLength: vlen = (data[4:0] == 0) ? 1 : (data[4:0] > 16 ? 16 : data[4:0]);
            RegRadius: rad = data[3:0];
            RegRate:   rate = data;
            RegMetric: city_block = data[0];
            default:   ;
        endcase
    endtask

    task automatic set_config(input int w, input int h, input int l, input int r,
                              input int lr, input bit m);
        wait_idle();
        cfg_write(RegWidth, w);
        cfg_write(RegHeight, h);
        cfg_write(RegLength, l);
        cfg_write(RegRadius, r);
        cfg_write(RegRate, lr);
        cfg_write(RegMetric, m);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return $urandom_range(0, 16'hffff);
        endcase
    endfunction

    // Every weight the search will touch must hold a value first.
    task automatic load_region();
        for (int n = 0; n < cols * rows; n++)
            for (int k = 0; k < vlen; k++)
                if (!wt_known[n][k]) send_item(OpWrite, n, k, rand_value(), 1'b0);
    endtask

    task automatic send_sample(input logic [1:0] o);
        for (int k = 0; k < vlen; k++)
            send_item(o, $urandom_range(0, 255), k, rand_value(), k == vlen - 1);
    endtask

    task automatic send_read();
        int n, k;
        n = 0;
        k = 0;
        for (int t = 0; t < 8; t++)
        begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                          : $urandom_range(0, cols * rows - 1);
            k = $urandom_range(0, 15);
            if (wt_known[n][k]) break;
            n = 0;
            k = 0;
        end
        send_item(OpRead, n, k, $urandom_range(0, 16'hffff), $urandom_range(0, 1));
    endtask

    task automatic random_phase(input int count);
        int  start, k;
        bit  all_known;
        logic [1:0] kind;
        load_region();
        if (!smp_known[0]) send_sample(OpClassify);
        start = n_items;
        while (n_items - start < count)
        begin
            kind = $urandom_range(0, 1) ? OpTrain : OpClassify;
            case ($urandom_range(0, 19))
                0, 1, 2:
                    send_item(OpWrite, $urandom_range(0, 255), $urandom_range(0, 15),
                              rand_value(), $urandom_range(0, 1));
                3, 4, 5:
                    send_read();
                6:
                    send_item(kind, $urandom_range(0, 255), $urandom_range(0, 15),
                              rand_value(), 1'b0);
                7:
                begin
                    // A sample cut short: last comes early on an already filled buffer.
                    all_known = 1'b1;
                    for (int i = 0; i < vlen; i++) all_known &= smp_known[i];
                    k = $urandom_range(0, 15);
                    if (all_known)
                        send_item(kind, $urandom_range(0, 255), k, rand_value(), 1'b1);
                end
                default:
                    send_sample(kind);
            endcase
        end
    endtask

    task automatic test_weight_access();
        set_config(0, 1, 0, 0, 16'hffff, 1'b1);
        send_item(OpWrite, 0, 0, 16'h8000, 1'b0);
        send_item(OpWrite, 255, 15, 16'h7fff, 1'b1);
        send_item(OpWrite, 170, 5, 16'h0000, 1'b0);
        send_item(OpRead, 0, 0, 16'h0000, 1'b0);
        send_item(OpRead, 255, 15, 16'hffff, 1'b1);
        send_item(OpRead, 170, 5, 16'h0000, 1'b0);
    endtask

    task automatic test_directed_search();
        // Single node, largest absolute distance, both metrics and both rate extremes.
        send_item(OpClassify, 0, 0, 16'h7fff, 1'b1);
        send_item(OpTrain, 0, 0, 16'h7fff, 1'b1);
        send_item(OpRead, 0, 0, 16'h0000, 1'b0);
        set_config(4, 31, 3, 15, 0, 1'b0);
        load_region();
        send_sample(OpClassify);
        send_sample(OpTrain);
        send_item(OpRead, 0, 0, 16'h0000, 1'b0);
        set_config(2, 2, 2, 0, 32768, 1'b0);
        send_sample(OpTrain);
        send_sample(OpTrain);
    endtask

    task automatic test_random();
        int w, h, l;
        set_config(16, 16, 1, $urandom_range(0, 15), $urandom_range(0, 65535), 1'b1);
        random_phase(60);
        set_config(31, 1, 16, $urandom_range(0, 15), $urandom_range(0, 65535), 1'b0);
        random_phase(60);
        while (n_items < 1080)
        begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 16);
            l = $urandom_range(1, 16);
            while (w * h * l > 256)
            begin
                if (l > 1) l--;
                else if (h > 1) h--;
                else w--;
            end
            set_config(w, h, l, $urandom_range(0, 15), $urandom_range(0, 65535),
                       $urandom_range(0, 1));
            random_phase(90);
        end
    endtask

    task automatic test_backpressure();
        set_config(3, 3, 4, 1, 40000, 1'b0);
        load_region();
        hold_req = 1'b1;
        repeat (6) send_read();
        send_sample(OpTrain);
        wait_idle();
        send_sample(OpClassify);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_weight_access();
        test_directed_search();
        test_backpressure();
        test_random();
        quiet = 1'b1;
        random_phase(80);
        wait_idle();
        $display("Ran %0d items: %0d trained samples, %0d classified, %0d reads,",
                 n_items, n_trained, n_classified, n_reads);
        $display("%0d results checked over varied grid, length, radius, rate and metric.",
                 n_results);
        if (errors == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
